>>> src/otlc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the overlay texture lru cache
// no dependencies

package otlc_pkg;

    localparam int KEY_W   = 64;
    localparam int GEN_W   = 64;
    localparam int DIM_W   = 15;
    localparam int BYTES_W = 31;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 3;
    localparam int CNT_W   = 32;
    localparam int CLK_W   = 64;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [STAT_W-1:0] ST_HIT         = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSTALLED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISMATCH    = 3'd3;
    localparam logic [STAT_W-1:0] ST_UPLOAD_FAIL = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED     = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic decide;
        logic scan_step;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } dp_stat_t;

endpackage

>>> src/otlc_ctrl.sv
`timescale 1ns / 1ps
// controller state machine for the overlay texture lru cache
// depends on otlc_pkg

module otlc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  otlc_pkg::dp_stat_t stat,
    output otlc_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       room;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign room      = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.need_scan ? S_SCAN : S_OUT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (room)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> src/otlc_dp.sv
`timescale 1ns / 1ps
// datapath for the overlay texture lru cache: entry lanes, checks, victim scan
// depends on otlc_pkg

module otlc_dp
#(
    parameter int CACHE_ENTRIES = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  otlc_pkg::dp_cmd_t             cmd,
    output otlc_pkg::dp_stat_t            stat,
    input  logic                          command,
    input  logic [otlc_pkg::KEY_W-1:0]    overlay_key,
    input  logic [otlc_pkg::GEN_W-1:0]    generation,
    input  logic [otlc_pkg::DIM_W-1:0]    width,
    input  logic [otlc_pkg::DIM_W-1:0]    height,
    input  logic                          has_payload,
    input  logic [otlc_pkg::BYTES_W-1:0]  payload_bytes,
    input  logic                          upload_ok,
    output logic [otlc_pkg::STAT_W-1:0]   status,
    output logic [otlc_pkg::SLOT_W-1:0]   slot,
    output logic [otlc_pkg::DIM_W-1:0]    texture_width,
    output logic [otlc_pkg::DIM_W-1:0]    texture_height,
    output logic [otlc_pkg::CNT_W-1:0]    hit_count,
    output logic [otlc_pkg::CNT_W-1:0]    upload_count
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    // request
    logic                         req_clear_reg;
    logic [otlc_pkg::KEY_W-1:0]   req_key_reg;
    logic [otlc_pkg::GEN_W-1:0]   req_gen_reg;
    logic [otlc_pkg::DIM_W-1:0]   req_w_reg;
    logic [otlc_pkg::DIM_W-1:0]   req_h_reg;
    logic                         req_payload_reg;
    logic [otlc_pkg::BYTES_W-1:0] req_bytes_reg;
    logic                         req_upload_reg;

    // check results
    logic                         empty_reg;
    logic                         mismatch_reg;
    logic [CACHE_ENTRIES-1:0]     hit_vec_reg;

    // entry store
    logic [CACHE_ENTRIES-1:0]     valid_reg;
    logic [otlc_pkg::CLK_W-1:0]   ts_reg    [CACHE_ENTRIES];
    logic [otlc_pkg::KEY_W-1:0]   key_reg   [CACHE_ENTRIES];
    logic [otlc_pkg::GEN_W-1:0]   gen_reg   [CACHE_ENTRIES];
    logic [otlc_pkg::DIM_W-1:0]   ew_reg    [CACHE_ENTRIES];
    logic [otlc_pkg::DIM_W-1:0]   eh_reg    [CACHE_ENTRIES];
    logic [otlc_pkg::CLK_W-1:0]   use_clock_reg;
    logic [otlc_pkg::CNT_W-1:0]   hits_reg;
    logic [otlc_pkg::CNT_W-1:0]   installs_reg;

    // victim scan
    logic [IDX_W-1:0]             scan_idx_reg;
    logic [IDX_W-1:0]             choice_reg;
    logic [otlc_pkg::CLK_W-1:0]   choice_ts_reg;

    // pending result
    logic [otlc_pkg::STAT_W-1:0]  res_status_reg;
    logic [IDX_W-1:0]             res_slot_reg;
    logic [otlc_pkg::DIM_W-1:0]   res_tw_reg;
    logic [otlc_pkg::DIM_W-1:0]   res_th_reg;

    // output beat
    logic [otlc_pkg::STAT_W-1:0]  out_status_reg;
    logic [otlc_pkg::SLOT_W-1:0]  out_slot_reg;
    logic [otlc_pkg::DIM_W-1:0]   out_tw_reg;
    logic [otlc_pkg::DIM_W-1:0]   out_th_reg;
    logic [otlc_pkg::CNT_W-1:0]   out_hits_reg;
    logic [otlc_pkg::CNT_W-1:0]   out_installs_reg;

    logic [CACHE_ENTRIES-1:0]     hit_vec;
    logic [2*otlc_pkg::DIM_W-1:0] dim_product;
    logic [2*otlc_pkg::DIM_W+1:0] expect_bytes;
    logic                         empty_now;
    logic                         mismatch_now;
    logic [IDX_W-1:0]             hit_idx;
    logic                         any_hit;
    logic                         need_scan;
    logic                         lookup_ok;
    logic                         dec_hit;
    logic [otlc_pkg::STAT_W-1:0]  dec_status;
    logic [otlc_pkg::CLK_W-1:0]   clock_inc;
    logic [otlc_pkg::CLK_W-1:0]   scan_ts;
    logic                         scan_invalid;
    logic                         scan_done;
    logic [IDX_W-1:0]             victim;
    logic                         do_install;
    logic [IDX_W+otlc_pkg::SLOT_W-1:0] slot_wide;

    assign empty_now    = !req_payload_reg || (req_w_reg == '0) || (req_h_reg == '0);
    assign dim_product  = (2*otlc_pkg::DIM_W)'(req_w_reg) * (2*otlc_pkg::DIM_W)'(req_h_reg);
    assign expect_bytes = {dim_product, 2'b00};
    assign mismatch_now = expect_bytes != {1'b0, req_bytes_reg};

    always_comb
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == req_key_reg)
                      && (gen_reg[i] == req_gen_reg) && (ew_reg[i] == req_w_reg)
                      && (eh_reg[i] == req_h_reg);
        end
    end

    // first matching entry wins
    always_comb
    begin
        hit_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit   = |hit_vec_reg;
    assign lookup_ok = !req_clear_reg && !empty_reg && !mismatch_reg;
    assign need_scan = lookup_ok && !any_hit && req_upload_reg;
    assign dec_hit   = lookup_ok && any_hit;
    assign clock_inc = use_clock_reg + 1'b1;

    always_comb
    begin
        priority if (req_clear_reg)
        begin
            dec_status = otlc_pkg::ST_CLEARED;
        end
        else if (empty_reg)
        begin
            dec_status = otlc_pkg::ST_EMPTY;
        end
        else if (mismatch_reg)
        begin
            dec_status = otlc_pkg::ST_MISMATCH;
        end
        else if (any_hit)
        begin
            dec_status = otlc_pkg::ST_HIT;
        end
        else
        begin
            dec_status = otlc_pkg::ST_UPLOAD_FAIL;
        end
    end

    assign scan_ts      = ts_reg[scan_idx_reg];
    assign scan_invalid = !valid_reg[scan_idx_reg];
    assign scan_done    = scan_invalid || (scan_idx_reg == LAST_IDX);
    assign do_install   = cmd.scan_step && scan_done;

    always_comb
    begin
        priority if (scan_invalid)
        begin
            victim = scan_idx_reg;
        end
        else if (scan_ts < choice_ts_reg)
        begin
            victim = scan_idx_reg;
        end
        else
        begin
            victim = choice_reg;
        end
    end

    assign stat.need_scan = need_scan;
    assign stat.scan_done = scan_done;

    assign slot_wide = {{otlc_pkg::SLOT_W{1'b0}}, res_slot_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_clear_reg   <= (command == otlc_pkg::CMD_CLEAR);
            req_key_reg     <= overlay_key;
            req_gen_reg     <= generation;
            req_w_reg       <= width;
            req_h_reg       <= height;
            req_payload_reg <= has_payload;
            req_bytes_reg   <= payload_bytes;
            req_upload_reg  <= upload_ok;
        end
        if (cmd.check)
        begin
            empty_reg    <= empty_now;
            mismatch_reg <= mismatch_now;
            hit_vec_reg  <= hit_vec;
        end
        if (do_install)
        begin
            key_reg[victim] <= req_key_reg;
            gen_reg[victim] <= req_gen_reg;
            ew_reg[victim]  <= req_w_reg;
            eh_reg[victim]  <= req_h_reg;
        end
        if (cmd.decide)
        begin
            res_status_reg <= dec_status;
            res_slot_reg   <= dec_hit ? hit_idx : '0;
            res_tw_reg     <= dec_hit ? req_w_reg : '0;
            res_th_reg     <= dec_hit ? req_h_reg : '0;
        end
        else if (do_install)
        begin
            res_status_reg <= otlc_pkg::ST_INSTALLED;
            res_slot_reg   <= victim;
            res_tw_reg     <= req_w_reg;
            res_th_reg     <= req_h_reg;
        end
        if (cmd.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_slot_reg     <= slot_wide[otlc_pkg::SLOT_W-1:0];
            out_tw_reg       <= res_tw_reg;
            out_th_reg       <= res_th_reg;
            out_hits_reg     <= hits_reg;
            out_installs_reg <= installs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            use_clock_reg <= '0;
            hits_reg      <= '0;
            installs_reg  <= '0;
            scan_idx_reg  <= '0;
            choice_reg    <= '0;
            choice_ts_reg <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                ts_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.decide)
            begin
                if (req_clear_reg)
                begin
                    valid_reg     <= '0;
                    use_clock_reg <= '0;
                    for (int i = 0; i < CACHE_ENTRIES; i++)
                    begin
                        ts_reg[i] <= '0;
                    end
                end
                else if (lookup_ok)
                begin
                    use_clock_reg <= clock_inc;
                    if (any_hit)
                    begin
                        hits_reg        <= hits_reg + 1'b1;
                        ts_reg[hit_idx] <= clock_inc;
                    end
                end
                scan_idx_reg  <= IDX_W'(1);
                choice_reg    <= '0;
                choice_ts_reg <= ts_reg[0];
            end
            if (cmd.scan_step)
            begin
                scan_idx_reg  <= scan_idx_reg + 1'b1;
                choice_reg    <= victim;
                choice_ts_reg <= (victim == scan_idx_reg) ? scan_ts : choice_ts_reg;
                if (scan_done)
                begin
                    valid_reg[victim] <= 1'b1;
                    ts_reg[victim]    <= use_clock_reg;
                    installs_reg      <= installs_reg + 1'b1;
                end
            end
        end
    end

    assign status         = out_status_reg;
    assign slot           = out_slot_reg;
    assign texture_width  = out_tw_reg;
    assign texture_height = out_th_reg;
    assign hit_count      = out_hits_reg;
    assign upload_count   = out_installs_reg;

endmodule

>>> src/overlay_texture_lru_cache_top.sv
`timescale 1ns / 1ps
// channel   handshake             payload
// in        in_valid / in_ready   command overlay_key generation width height
//                                 has_payload payload_bytes upload_ok
// out       out_valid / out_ready status slot texture_width texture_height
//                                 hit_count upload_count
//
// one item at a time: accept, check, decide and output steps; the result
// register loads once the output state has room, and in_ready rises with
// it; an install adds a victim scan of one entry per cycle over entries
// 1 to CACHE_ENTRIES-1, ending early at the first invalid entry
// the size check runs through one 15x15 multiplier, tags compare in parallel
// reset clears valid bits, timestamps, use clock and counters at once
// a held result does not block accepting the next beat; only its final
// write waits for out_ready
// depends on otlc_pkg, otlc_ctrl, otlc_dp

module overlay_texture_lru_cache_top
#(
    parameter int CACHE_ENTRIES = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [otlc_pkg::KEY_W-1:0]    overlay_key,
    input  logic [otlc_pkg::GEN_W-1:0]    generation,
    input  logic [otlc_pkg::DIM_W-1:0]    width,
    input  logic [otlc_pkg::DIM_W-1:0]    height,
    input  logic                          has_payload,
    input  logic [otlc_pkg::BYTES_W-1:0]  payload_bytes,
    input  logic                          upload_ok,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [otlc_pkg::STAT_W-1:0]   status,
    output logic [otlc_pkg::SLOT_W-1:0]   slot,
    output logic [otlc_pkg::DIM_W-1:0]    texture_width,
    output logic [otlc_pkg::DIM_W-1:0]    texture_height,
    output logic [otlc_pkg::CNT_W-1:0]    hit_count,
    output logic [otlc_pkg::CNT_W-1:0]    upload_count
);

    otlc_pkg::dp_cmd_t  cmd;
    otlc_pkg::dp_stat_t stat;

    otlc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    otlc_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .command        (command),
        .overlay_key    (overlay_key),
        .generation     (generation),
        .width          (width),
        .height         (height),
        .has_payload    (has_payload),
        .payload_bytes  (payload_bytes),
        .upload_ok      (upload_ok),
        .status         (status),
        .slot           (slot),
        .texture_width  (texture_width),
        .texture_height (texture_height),
        .hit_count      (hit_count),
        .upload_count   (upload_count)
    );

endmodule

>>> src/otlc_checker.sv
`timescale 1ns / 1ps
// port level checks for the overlay texture lru cache, bound to the top level
// depends on otlc_pkg and overlay_texture_lru_cache_top

module otlc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [otlc_pkg::STAT_W-1:0] status,
    input logic [otlc_pkg::SLOT_W-1:0] slot,
    input logic [otlc_pkg::DIM_W-1:0]  texture_width,
    input logic [otlc_pkg::DIM_W-1:0]  texture_height
);

    // stalled beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("output beat dropped or changed while stalled");

    // only hit or install carries a slot and size
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != otlc_pkg::ST_HIT && status != otlc_pkg::ST_INSTALLED
        |-> slot == '0 && texture_width == '0 && texture_height == '0)
        else $error("slot or size on a beat without an entry");

    // a hit or install always has a nonzero size
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == otlc_pkg::ST_HIT || status == otlc_pkg::ST_INSTALLED)
        |-> texture_width != '0 && texture_height != '0)
        else $error("entry beat with zero size");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= otlc_pkg::ST_CLEARED)
        else $error("status code out of range");

endmodule

bind overlay_texture_lru_cache_top otlc_checker u_checker (.*);
